// ----- rtl/core/tdpt_pkg.sv -----
// ----------------------------------------------------------------------------
// tdpt_pkg: shared types and constants of the trial division prime test
// Field widths, port padding, and the command/status structs that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package tdpt_pkg;

	// candidate width
	localparam int NUMBER_BITS = 31;

	// divisor width: holds the first divisor whose square passes the candidate
	localparam int DIV_BITS = (NUMBER_BITS + 1) / 2 + 1;

	// square of the divisor
	localparam int SQ_BITS = 2 * DIV_BITS;

	// remainder width during the shift-subtract pass
	localparam int REM_BITS = DIV_BITS + 1;

	// bit counter of the remainder pass
	localparam int CNT_BITS = $clog2(NUMBER_BITS);

	// stream data widths, padded to whole bytes
	localparam int IN_DATA_BITS  = ((NUMBER_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_BITS = 8;

	// first odd trial divisor and its square
	localparam int FIRST_ODD_DIV = 3;
	localparam int FIRST_ODD_SQ  = 9;

	// smallest prime
	localparam int SMALLEST_PRIME = 2;

	// controller to datapath
	typedef struct packed {
		logic load;        // take a new candidate, start at the first odd divisor
		logic div_start;   // clear remainder, start the bit counter
		logic div_step;    // one shift-subtract step
		logic advance;     // move to the next odd divisor
		logic out_load;    // write the result register
		logic flag;        // value written to the result register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic below_two;
		logic is_two;
		logic is_even;
		logic over;        // divisor squared exceeds the candidate
		logic div_last;    // last step of the remainder pass
		logic rem_zero;
	} status_t;

endpackage

// ----- rtl/core/tdpt_datapath.sv -----
// ----------------------------------------------------------------------------
// tdpt_datapath: candidate, divisor and remainder registers
// Holds the candidate, the odd trial divisor with its square (updated by
// additions only), and a restoring remainder unit that handles one
// candidate bit per cycle. Also holds the result data register.
// ----------------------------------------------------------------------------
module tdpt_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tdpt_pkg::cmd_t                      cmd,
	input  logic [tdpt_pkg::NUMBER_BITS-1:0]    candidate,
	output tdpt_pkg::status_t                   status,
	output logic                                prime_flag
);

	logic [tdpt_pkg::NUMBER_BITS-1:0] n_q;
	logic [tdpt_pkg::DIV_BITS-1:0]    d_q;
	logic [tdpt_pkg::SQ_BITS-1:0]     sq_q;
	logic [tdpt_pkg::REM_BITS-1:0]    rem_q;
	logic [tdpt_pkg::CNT_BITS-1:0]    cnt_q;
	logic                             flag_q;

	logic [tdpt_pkg::REM_BITS-1:0]    rem_shift;
	logic [tdpt_pkg::REM_BITS-1:0]    d_ext;
	logic [tdpt_pkg::SQ_BITS-1:0]     n_ext;
	logic [tdpt_pkg::SQ_BITS-1:0]     d_sq_ext;

	// shift in the next candidate bit, msb first
	assign rem_shift = {rem_q[tdpt_pkg::REM_BITS-2:0], n_q[cnt_q]};
	assign d_ext     = {1'b0, d_q};
	assign n_ext     = tdpt_pkg::SQ_BITS'(n_q);
	assign d_sq_ext  = tdpt_pkg::SQ_BITS'(d_q);

	// candidate, divisor and square
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q  <= candidate;
			d_q  <= tdpt_pkg::DIV_BITS'(tdpt_pkg::FIRST_ODD_DIV);
			sq_q <= tdpt_pkg::SQ_BITS'(tdpt_pkg::FIRST_ODD_SQ);
		end else if (cmd.advance) begin
			// (d+2)^2 = d^2 + 4d + 4
			d_q  <= d_q + tdpt_pkg::DIV_BITS'(2);
			sq_q <= sq_q + (d_sq_ext << 2) + tdpt_pkg::SQ_BITS'(4);
		end
	end

	// restoring remainder, one bit per cycle
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= '0;
			cnt_q <= tdpt_pkg::CNT_BITS'(tdpt_pkg::NUMBER_BITS - 1);
		end else if (cmd.div_step) begin
			if (rem_shift >= d_ext) begin
				rem_q <= rem_shift - d_ext;
			end else begin
				rem_q <= rem_shift;
			end
			cnt_q <= cnt_q - tdpt_pkg::CNT_BITS'(1);
		end
	end

	// result data
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			flag_q <= cmd.flag;
		end
	end

	// status to the controller
	assign status.below_two = n_q < tdpt_pkg::NUMBER_BITS'(tdpt_pkg::SMALLEST_PRIME);
	assign status.is_two    = n_q == tdpt_pkg::NUMBER_BITS'(tdpt_pkg::SMALLEST_PRIME);
	assign status.is_even   = ~n_q[0];
	assign status.over      = sq_q > n_ext;
	assign status.div_last  = cnt_q == '0;
	assign status.rem_zero  = rem_q == '0;

	assign prime_flag = flag_q;

	// reset input kept for the house port set; payload registers need none
	logic unused_rst;
	assign unused_rst = arst_n;

endmodule

// ----- rtl/core/tdpt_ctrl.sv -----
// ----------------------------------------------------------------------------
// tdpt_ctrl: sequencer of the trial division prime test
// Steps through the small-value checks, one remainder pass per odd
// divisor, and the result hand-off; owns the stream valid/ready.
// ----------------------------------------------------------------------------
module tdpt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  tdpt_pkg::status_t  status,
	output tdpt_pkg::cmd_t     cmd
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_CHECK = 5'b00010,
		ST_DIV   = 5'b00100,
		ST_NEXT  = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   flag_q, flag_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = ~out_valid_q | out_ready;

	// next state and commands
	always_comb begin
		state_d = state_q;
		flag_d  = flag_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				priority if (status.below_two) begin
					flag_d  = 1'b0;
					state_d = ST_DONE;
				end else if (status.is_two) begin
					flag_d  = 1'b1;
					state_d = ST_DONE;
				end else if (status.is_even) begin
					flag_d  = 1'b0;
					state_d = ST_DONE;
				end else if (status.over) begin
					flag_d  = 1'b1;
					state_d = ST_DONE;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = ST_NEXT;
				end
			end
			ST_NEXT: begin
				if (status.rem_zero) begin
					flag_d  = 1'b0;
					state_d = ST_DONE;
				end else begin
					cmd.advance = 1'b1;
					state_d     = ST_CHECK;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		cmd.flag = flag_q;
	end

	// state, pending flag and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			flag_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			flag_q  <= flag_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;

endmodule

// ----- rtl/core/trial_division_prime_test.sv -----
// ----------------------------------------------------------------------------
// trial_division_prime_test: primality test by trial division
// Tests one candidate per transfer and returns one prime flag per transfer.
// ----------------------------------------------------------------------------
//
// channel   dir  fields (lsb up)                        width
// s_axis    in   tdata: candidate[30:0], zero pad        32
// m_axis    out  tdata: prime_flag[0], zero pad          8
//
// timing: values below two, two and even values are settled in the check state
// and go straight to the result hand-off; odd values run, for each odd divisor
// tried (up to ~23170), a check state, 31 one-bit remainder steps and a test
// state.
// reset: arst_n clears the sequencer and the result valid; no memories.
// stalls: a held result does not block the next input transfer; the block
// waits in its final state only until the result register is free.
//
module trial_division_prime_test (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [tdpt_pkg::IN_DATA_BITS-1:0]   s_tdata,   // candidate, zero pad
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [tdpt_pkg::OUT_DATA_BITS-1:0]  m_tdata    // prime_flag, zero pad
);

	tdpt_pkg::cmd_t    cmd;
	tdpt_pkg::status_t status;
	logic              prime_flag;
	logic [tdpt_pkg::IN_DATA_BITS-tdpt_pkg::NUMBER_BITS-1:0] unused_pad;

	assign unused_pad = s_tdata[tdpt_pkg::IN_DATA_BITS-1:tdpt_pkg::NUMBER_BITS];

	// sequencer
	tdpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.status    (status),
		.cmd       (cmd)
	);

	// registers and remainder unit
	tdpt_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.candidate  (s_tdata[tdpt_pkg::NUMBER_BITS-1:0]),
		.status     (status),
		.prime_flag (prime_flag)
	);

	assign m_tdata = {{(tdpt_pkg::OUT_DATA_BITS-1){1'b0}}, prime_flag};

endmodule

// ----- rtl/core/tdpt_checker.sv -----
// ----------------------------------------------------------------------------
// tdpt_checker: port-level checks of the trial division prime test
// Watches the stream ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module tdpt_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_tvalid,
	input logic                                s_tready,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [tdpt_pkg::OUT_DATA_BITS-1:0]  m_tdata
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one candidate at a time
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after an input transfer");

	// a result never appears in the cycle after an input transfer
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result valid too early");

	// padding bits of the result stay zero
	a_out_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[tdpt_pkg::OUT_DATA_BITS-1:1] == '0)
		else $error("nonzero result padding");

endmodule

bind trial_division_prime_test tdpt_checker u_tdpt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the trial division prime test
// Streams candidates into the block and checks each returned prime flag
// against a local trial-division predictor, in order. Directed values cover
// values below two, two, squares of primes, the largest values of the field
// and a set pad bit. Random values follow under three idle patterns, plus a
// long output hold-off that fills the block and stalls its input.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CLK_PERIOD   = 12;
	localparam int MAX_REPORTS  = 10;
	localparam int TAIL_CYCLES  = 50;
	localparam int HOLD_CYCLES  = 300;

	// one pending answer: the candidate and its predicted flag
	typedef struct {
		logic [tdpt_pkg::NUMBER_BITS-1:0] candidate;
		logic                             prime_flag;
	} prime_answer_t;

	logic                                clk;
	logic                                arst_n;
	logic                                s_tvalid;
	logic                                s_tready;
	logic [tdpt_pkg::IN_DATA_BITS-1:0]   s_tdata;   // candidate[30:0], zero pad
	logic                                m_tvalid;
	logic                                m_tready;
	logic [tdpt_pkg::OUT_DATA_BITS-1:0]  m_tdata;   // prime_flag[0], zero pad

	prime_answer_t pending_answers[$];
	int unsigned   mismatch_count;
	int unsigned   send_idle_pct;
	int unsigned   recv_idle_pct;
	int unsigned   hold_left;

	trial_division_prime_test dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// trial division up to the square root, odd divisors after two
	function automatic logic predict_prime(input logic [tdpt_pkg::NUMBER_BITS-1:0] n);
		longint unsigned value;
		longint unsigned d;
		value = n;
		if (value < tdpt_pkg::SMALLEST_PRIME)
			return 1'b0;
		if (value == tdpt_pkg::SMALLEST_PRIME)
			return 1'b1;
		if (value % tdpt_pkg::SMALLEST_PRIME == 0)
			return 1'b0;
		for (d = tdpt_pkg::FIRST_ODD_DIV; d <= value / d; d += 2) begin
			if (value % d == 0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// offer one candidate word, with random idle cycles before it
	task automatic send_candidate(input logic [tdpt_pkg::IN_DATA_BITS-1:0] word);
		prime_answer_t answer;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata  <= $urandom;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		answer.candidate  = word[tdpt_pkg::NUMBER_BITS-1:0];
		answer.prime_flag = predict_prime(word[tdpt_pkg::NUMBER_BITS-1:0]);
		pending_answers.push_back(answer);
		@(negedge clk);
	endtask

	// receiver: random stalls, or a counted hold-off when requested
	always @(negedge clk) begin
		if (hold_left != 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// compare each output transfer with the oldest pending answer
	always @(posedge clk) begin
		prime_answer_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_answers.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected flag %0b with no candidate pending", m_tdata[0]);
			end else begin
				want = pending_answers.pop_front();
				if (m_tdata[0] !== want.prime_flag) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("candidate %0d: expected flag %0b, got %0b",
							want.candidate, want.prime_flag, m_tdata[0]);
				end
			end
		end
	end

	// values below two, two, and small primes and composites
	task automatic test_small_values();
		send_candidate(32'd0);
		send_candidate(32'd1);
		send_candidate(32'd2);
		send_candidate(32'd3);
		send_candidate(32'd4);
		send_candidate(32'd5);
		send_candidate(32'd15);
		send_candidate(32'd97);
		send_candidate(32'd65521);
		send_candidate(32'd65536);
	endtask

	// squares of primes must come out composite
	task automatic test_prime_squares();
		send_candidate(32'd9);
		send_candidate(32'd25);
		send_candidate(32'd49);
		send_candidate(32'd121);
		send_candidate(32'd169);
		// square of the largest prime whose square fits the field
		send_candidate(32'd2147117569);
	endtask

	// top of the field, top bit alone, and a set pad bit that must be ignored
	task automatic test_field_extremes();
		send_candidate(32'h7FFF_FFFF);
		send_candidate(32'h7FFF_FFFE);
		send_candidate(32'h4000_0000);
		send_candidate(32'h8000_0007);
		send_candidate(32'h8000_0000);
	endtask

	// random candidates, mostly narrow and odd so that the loop runs
	task automatic test_random_candidates(input int unsigned count);
		logic [tdpt_pkg::IN_DATA_BITS-1:0] word;
		int unsigned                       width;
		repeat (count) begin
			if ($urandom_range(9) == 0) begin
				// multiples of three across the whole field stop early
				word = 3 * $urandom_range(1, 715827882);
			end else begin
				width = ($urandom_range(11) == 0) ? $urandom_range(21, 24)
					: $urandom_range(1, 20);
				word = $urandom & ((32'd1 << width) - 1);
				if ($urandom_range(9) < 7)
					word[0] = 1'b1;
			end
			word[tdpt_pkg::IN_DATA_BITS-1] = ($urandom_range(3) == 0);
			send_candidate(word);
		end
	endtask

	// hold the output off while fast candidates keep arriving
	task automatic test_output_backpressure();
		int unsigned saved_pct;
		saved_pct     = send_idle_pct;
		send_idle_pct = 0;
		hold_left     = HOLD_CYCLES;
		repeat (8)
			send_candidate({$urandom} & 32'h0000_FFFE);
		send_idle_pct = saved_pct;
	endtask

	// stimulus sequence
	initial begin
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		m_tready       = 1'b0;
		mismatch_count = 0;
		hold_left      = 0;
		send_idle_pct  = 38;
		recv_idle_pct  = 54;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_small_values();
		test_prime_squares();
		test_field_extremes();
		test_random_candidates(24);

		send_idle_pct = 54;
		recv_idle_pct = 38;
		test_random_candidates(23);
		test_output_backpressure();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_candidates(24);
		s_tvalid <= 1'b0;

		// drain, then watch for stray transfers
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && pending_answers.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// watchdog
	initial begin
		#480_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
